>>> sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int ID_W      = 16;
    localparam int PRI_W     = 8;
    localparam int OCC_W     = 5;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_POP_HEAD = 2'd1,
        OP_POP_TAIL = 2'd2,
        OP_REMOVE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic             en;
        op_t              op;
        logic [ID_W-1:0]  key_id;
        logic [PRI_W-1:0] key_pri;
    } cell_ctrl_t;

endpackage

>>> sv/sorted_priority_queue.sv
// Sorted priority queue built as a row of shifting cells.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser: op; tdata: item_id, item_priority
//  m_axis   out  m_axis_tvalid / m_axis_tready  tuser: status; tdata: out_id,
//                                               out_priority, occupancy
//
// For every operation all cells compare and shift together, and the result lands in the
// output register on the edge that accepts the beat.
// A new beat is taken each cycle the output register is empty or being drained.
// Reset clears the fill count and the output valid; cell contents are written before read.
// A stalled output holds the result and blocks further input until it is taken.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // item_id[15:0], item_priority[23:16]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_id[15:0], out_priority[23:16], occupancy[28:24]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             out_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    entry_t           out_entry_reg;
    entry_t           out_entry_next;
    logic [OCC_W-1:0] occ_reg;

    logic             accept;
    op_t              op;
    logic             full;
    logic             empty;
    cell_ctrl_t       ctrl;

    logic   [DEPTH-1:0] valid;
    logic   [DEPTH-1:0] keep;
    logic   [DEPTH-1:0] hit;
    logic   [DEPTH-1:0] sel;
    logic   [DEPTH:0]   found;
    entry_t             entries [DEPTH];

    assign op            = op_t'(s_axis_tuser);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = valid[DEPTH-1];
    assign empty         = !valid[0];

    always_comb
    begin
        ctrl.op      = op;
        ctrl.key_id  = s_axis_tdata[15:0];
        ctrl.key_pri = s_axis_tdata[23:16];
        if (op == OP_INSERT)
        begin
            ctrl.en = accept && !full;
        end
        else
        begin
            ctrl.en = accept && !empty;
        end
    end

    assign found[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            entry_t left_entry;
            entry_t right_entry;
            logic   left_keep;
            logic   tail;

            assign valid[g] = CNT_W'(g) < count_reg;

            if (g == 0)
            begin : g_first
                assign left_entry = '0;
                assign left_keep  = 1'b1;
            end
            else
            begin : g_mid
                assign left_entry = entries[g-1];
                assign left_keep  = keep[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_entry = '0;
                assign tail        = valid[g];
            end
            else
            begin : g_inner
                assign right_entry = entries[g+1];
                assign tail        = valid[g] && !valid[g+1];
            end

            // Cell whose entry leaves the queue on a pop or remove.
            assign sel[g] = ((op == OP_POP_HEAD) && (g == 0) && valid[g])
                         || ((op == OP_POP_TAIL) && tail)
                         || ((op == OP_REMOVE) && hit[g]);

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .valid       (valid[g]),
                .left_entry  (left_entry),
                .left_keep   (left_keep),
                .right_entry (right_entry),
                .found_in    (found[g]),
                .entry       (entries[g]),
                .keep        (keep[g]),
                .found_out   (found[g+1]),
                .hit         (hit[g])
            );
        end
    endgenerate

    always_comb
    begin
        out_entry_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel[i])
            begin
                out_entry_next = out_entry_next | entries[i];
            end
        end
    end

    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        if (op == OP_INSERT)
        begin
            if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
        end
        else if ((op == OP_REMOVE) && !found[DEPTH])
        begin
            status_next = ST_NOT_FOUND;
        end
        else
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until the next accepted beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            occ_reg       <= OCC_W'(count_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {3'b000, occ_reg, out_entry_reg.pri, out_entry_reg.id};

endmodule

>>> sv/spq_cell.sv
// One slot of the queue: holds an entry and shifts with its neighbors.
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                valid,
    input  spq_pkg::entry_t     left_entry,
    input  logic                left_keep,
    input  spq_pkg::entry_t     right_entry,
    input  logic                found_in,
    output spq_pkg::entry_t     entry,
    output logic                keep,
    output logic                found_out,
    output logic                hit
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   match;

    assign entry     = entry_reg;
    // Entry stays in place on insert when it ranks at or above the new one.
    assign keep      = valid && (entry_reg.pri >= ctrl.key_pri);
    assign match     = valid && (entry_reg.id == ctrl.key_id);
    assign hit       = match && !found_in;
    assign found_out = found_in || match;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.en)
        begin
            unique case (ctrl.op)
                OP_INSERT:
                begin
                    if (!keep)
                    begin
                        if (left_keep)
                        begin
                            entry_next.id  = ctrl.key_id;
                            entry_next.pri = ctrl.key_pri;
                        end
                        else
                        begin
                            entry_next = left_entry;
                        end
                    end
                end
                OP_POP_HEAD:
                begin
                    entry_next = right_entry;
                end
                OP_POP_TAIL:
                begin
                    entry_next = entry_reg;
                end
                OP_REMOVE:
                begin
                    // Close the gap behind the first match.
                    if (found_out)
                    begin
                        entry_next = right_entry;
                    end
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule
